>>> hw/rtl/bms_pkg.sv
package bms_pkg;

    // Key and tag widths and the lane count of one chunk
    localparam int KEY_WIDTH = 32;
    localparam int TAG_WIDTH = 32;
    localparam int LANES     = 4;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [TAG_WIDTH-1:0] t_tag;

    // One result word as it waits in the output queue
    typedef struct packed {
        t_key [LANES-1:0] key;
        t_tag [LANES-1:0] tag;
        logic             run_end;
    } t_word;

endpackage

>>> hw/rtl/bitonic_merge_4x4_stream_core.sv
// Streaming 4+4 bitonic merge of two ascending key/tag lists.
//
// Input channel (i_in_valid / o_in_ready): one chunk of four ascending keys,
// a tag for each key and a final_chunk flag. Output channel (o_out_valid /
// i_out_ready): four merged keys with their tags and a run_end flag.
//
// The first chunk after reset or after a final chunk is only held. Each later
// chunk is merged with the held four pairs; the lower four go out and the
// upper four stay held. A final chunk instead sends the upper four as a second
// word with run_end set. A final chunk with nothing held goes out as is.
//
// The first word of a taken chunk is registered and heads the queue in the following cycle.
// Throughput: one chunk per cycle while the receiver is ready; the three compare
// levels sit between the held registers and a two-entry output queue. A final
// chunk with a merge in flight gives two words, fills both queue entries and
// blocks the input for the next cycle even with the receiver ready.
// When the receiver stalls, the queue fills and o_in_ready drops: it is high
// with the queue empty, or with one word queued that is taken this cycle.
// Reset (i_rst_n low, synchronous) empties the queue and drops the held pairs.
module bitonic_merge_4x4_stream_core
    import bms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [KEY_WIDTH-1:0] i_key_0,
    input  logic [KEY_WIDTH-1:0] i_key_1,
    input  logic [KEY_WIDTH-1:0] i_key_2,
    input  logic [KEY_WIDTH-1:0] i_key_3,
    input  logic [TAG_WIDTH-1:0] i_tag_0,
    input  logic [TAG_WIDTH-1:0] i_tag_1,
    input  logic [TAG_WIDTH-1:0] i_tag_2,
    input  logic [TAG_WIDTH-1:0] i_tag_3,
    input  logic                 i_final_chunk,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KEY_WIDTH-1:0] o_out_key_0,
    output logic [KEY_WIDTH-1:0] o_out_key_1,
    output logic [KEY_WIDTH-1:0] o_out_key_2,
    output logic [KEY_WIDTH-1:0] o_out_key_3,
    output logic [TAG_WIDTH-1:0] o_out_tag_0,
    output logic [TAG_WIDTH-1:0] o_out_tag_1,
    output logic [TAG_WIDTH-1:0] o_out_tag_2,
    output logic [TAG_WIDTH-1:0] o_out_tag_3,
    output logic                 o_run_end
);

    // Held half of the merge
    t_key [LANES-1:0] r_held_key;
    t_tag [LANES-1:0] r_held_tag;
    logic             r_held_vld;
    t_key [LANES-1:0] n_held_key;
    t_tag [LANES-1:0] n_held_tag;
    logic             n_held_vld;

    // Output queue, entry 0 is the head
    t_word            r_q [2];
    logic [1:0]       r_cnt;
    t_word            n_q [2];
    logic [1:0]       n_cnt;

    logic             in_acc;
    logic             out_pop;
    logic             push_one;
    logic             push_two;
    t_word            word_0;
    t_word            word_1;

    // Network signals
    t_key [LANES-1:0] chunk_key;
    t_tag [LANES-1:0] chunk_tag;
    t_key [LANES-1:0] l1_lo_k, l1_hi_k, l2_lo_k, l2_hi_k, l3_lo_k, l3_hi_k;
    t_tag [LANES-1:0] l1_lo_t, l1_hi_t, l2_lo_t, l2_hi_t, l3_lo_t, l3_hi_t;
    t_key [LANES-1:0] lower_k, upper_k;
    t_tag [LANES-1:0] lower_t, upper_t;

    assign chunk_key = {i_key_3, i_key_2, i_key_1, i_key_0};
    assign chunk_tag = {i_tag_3, i_tag_2, i_tag_1, i_tag_0};

    // Three compare levels; a lane swaps only where the low-side key is greater
    always_comb begin
        t_key sk;
        t_tag st;
        sk = '0;
        st = '0;
        // Level 1: held against the reversed chunk
        for (int i = 0; i < LANES; i++) begin
            l1_lo_k[i] = r_held_key[i];
            l1_lo_t[i] = r_held_tag[i];
            l1_hi_k[i] = chunk_key[LANES-1-i];
            l1_hi_t[i] = chunk_tag[LANES-1-i];
            if (l1_lo_k[i] > l1_hi_k[i]) begin
                sk = l1_lo_k[i];  st = l1_lo_t[i];
                l1_lo_k[i] = l1_hi_k[i];  l1_lo_t[i] = l1_hi_t[i];
                l1_hi_k[i] = sk;  l1_hi_t[i] = st;
            end
        end

        // Level 2: lo = [L0,L1,H2,H3], hi = [L2,L3,H0,H1]
        l2_lo_k = {l1_hi_k[3], l1_hi_k[2], l1_lo_k[1], l1_lo_k[0]};
        l2_lo_t = {l1_hi_t[3], l1_hi_t[2], l1_lo_t[1], l1_lo_t[0]};
        l2_hi_k = {l1_hi_k[1], l1_hi_k[0], l1_lo_k[3], l1_lo_k[2]};
        l2_hi_t = {l1_hi_t[1], l1_hi_t[0], l1_lo_t[3], l1_lo_t[2]};
        for (int i = 0; i < LANES; i++) begin
            if (l2_lo_k[i] > l2_hi_k[i]) begin
                sk = l2_lo_k[i];  st = l2_lo_t[i];
                l2_lo_k[i] = l2_hi_k[i];  l2_lo_t[i] = l2_hi_t[i];
                l2_hi_k[i] = sk;  l2_hi_t[i] = st;
            end
        end

        // Level 3: lo = [L0,H1,L2,H3], hi = [L1,H0,L3,H2]
        l3_lo_k = {l2_hi_k[3], l2_lo_k[2], l2_hi_k[1], l2_lo_k[0]};
        l3_lo_t = {l2_hi_t[3], l2_lo_t[2], l2_hi_t[1], l2_lo_t[0]};
        l3_hi_k = {l2_hi_k[2], l2_lo_k[3], l2_hi_k[0], l2_lo_k[1]};
        l3_hi_t = {l2_hi_t[2], l2_lo_t[3], l2_hi_t[0], l2_lo_t[1]};
        for (int i = 0; i < LANES; i++) begin
            if (l3_lo_k[i] > l3_hi_k[i]) begin
                sk = l3_lo_k[i];  st = l3_lo_t[i];
                l3_lo_k[i] = l3_hi_k[i];  l3_lo_t[i] = l3_hi_t[i];
                l3_hi_k[i] = sk;  l3_hi_t[i] = st;
            end
        end

        // Interleave into the lower and upper halves
        lower_k = {l3_hi_k[1], l3_lo_k[1], l3_hi_k[0], l3_lo_k[0]};
        lower_t = {l3_hi_t[1], l3_lo_t[1], l3_hi_t[0], l3_lo_t[0]};
        upper_k = {l3_hi_k[3], l3_lo_k[3], l3_hi_k[2], l3_lo_k[2]};
        upper_t = {l3_hi_t[3], l3_lo_t[3], l3_hi_t[2], l3_lo_t[2]};
    end

    // Handshakes
    assign out_pop    = (r_cnt != 2'd0) && i_out_ready;
    assign o_in_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    // Decide what the accepted chunk pushes and what stays held
    always_comb begin
        n_held_key = r_held_key;
        n_held_tag = r_held_tag;
        n_held_vld = r_held_vld;
        push_one   = 1'b0;
        push_two   = 1'b0;
        word_0     = '{key: lower_k, tag: lower_t, run_end: 1'b0};
        word_1     = '{key: upper_k, tag: upper_t, run_end: 1'b1};
        if (in_acc) begin
            if (!r_held_vld) begin
                if (i_final_chunk) begin
                    push_one = 1'b1;
                    word_0   = '{key: chunk_key, tag: chunk_tag, run_end: 1'b1};
                end else begin
                    n_held_key = chunk_key;
                    n_held_tag = chunk_tag;
                    n_held_vld = 1'b1;
                end
            end else begin
                push_one   = 1'b1;
                push_two   = i_final_chunk;
                n_held_key = upper_k;
                n_held_tag = upper_t;
                n_held_vld = !i_final_chunk;
            end
        end
    end

    // Advance the output queue: drop the head, then append new words
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (out_pop) begin
            n_q[0] = r_q[1];
            n_cnt  = r_cnt - 2'd1;
        end
        if (push_one) begin
            n_q[n_cnt[0]] = word_0;
        end
        if (push_two) begin
            n_q[1] = word_1;
        end
        n_cnt = n_cnt + {1'b0, push_one} + {1'b0, push_two};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= 2'd0;
            r_held_vld <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_held_vld <= n_held_vld;
        end
        r_held_key <= n_held_key;
        r_held_tag <= n_held_tag;
        r_q        <= n_q;
    end

    // Head of the queue drives the output word
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_key_0 = r_q[0].key[0];
    assign o_out_key_1 = r_q[0].key[1];
    assign o_out_key_2 = r_q[0].key[2];
    assign o_out_key_3 = r_q[0].key[3];
    assign o_out_tag_0 = r_q[0].tag[0];
    assign o_out_tag_1 = r_q[0].tag[1];
    assign o_out_tag_2 = r_q[0].tag[2];
    assign o_out_tag_3 = r_q[0].tag[3];
    assign o_run_end   = r_q[0].run_end;

endmodule

>>> hw/rtl/bms_checker.sv
module bms_checker
    import bms_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [KEY_WIDTH-1:0] o_out_key_0,
    input logic [TAG_WIDTH-1:0] o_out_tag_0,
    input logic                 o_run_end
);

    // A stalled word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    // A stalled word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_key_0) && $stable(o_out_tag_0)
            && $stable(o_run_end))
        else $error("output word changed while stalled");

    // Reset empties the output queue
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // An empty queue always takes a chunk
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output queue");

endmodule

bind bitonic_merge_4x4_stream_core bms_checker u_bms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_key_0 (o_out_key_0),
    .o_out_tag_0 (o_out_tag_0),
    .o_run_end   (o_run_end)
);
